/* rtl/rm2q_pkg.sv */
package rm2q_pkg;

	// Components of a quaternion, in the order x, y, z, w.
	localparam int LANES = 4;
	// Matrix entries of one item.
	localparam int N_ENTRIES = 9;
	// Width of the matrix entry and quaternion component ports.
	localparam int FIELD_W = 16;

	typedef logic [FIELD_W-1:0] field_t;

endpackage

/* rtl/rm2q_dir.sv */
module rm2q_dir #(
	parameter int FRAC_BITS = 14,
	parameter int DW = 19
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic v_in,
	input  rm2q_pkg::field_t [rm2q_pkg::N_ENTRIES-1:0] m,
	output logic v_s1,
	output logic [rm2q_pkg::LANES-1:0][DW-1:0] d_s1
);

	localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

	logic signed [DW-1:0] a00, a10, a20, a01, a11, a21, a02, a12, a22;
	logic signed [DW-1:0] tr, rx, ry, rz;
	logic [rm2q_pkg::LANES-1:0][DW-1:0] d_c;

	always_comb begin
		a00 = DW'($signed(m[0]));
		a10 = DW'($signed(m[1]));
		a20 = DW'($signed(m[2]));
		a01 = DW'($signed(m[3]));
		a11 = DW'($signed(m[4]));
		a21 = DW'($signed(m[5]));
		a02 = DW'($signed(m[6]));
		a12 = DW'($signed(m[7]));
		a22 = DW'($signed(m[8]));
		tr = a00 + a11 + a22;
		rx = ONE + a00 - a11 - a22;
		ry = ONE + a11 - a00 - a22;
		rz = ONE + a22 - a00 - a11;
		if (rx < 1) begin
			rx = DW'(1);
		end
		if (ry < 1) begin
			ry = DW'(1);
		end
		if (rz < 1) begin
			rz = DW'(1);
		end
		priority if (tr > 0) begin
			d_c[0] = a21 - a12;
			d_c[1] = a02 - a20;
			d_c[2] = a10 - a01;
			d_c[3] = ONE + tr;
		end else if (a00 > a11 && a00 > a22) begin
			d_c[0] = rx;
			d_c[1] = a01 + a10;
			d_c[2] = a02 + a20;
			d_c[3] = a21 - a12;
		end else if (a11 > a22) begin
			d_c[0] = a01 + a10;
			d_c[1] = ry;
			d_c[2] = a12 + a21;
			d_c[3] = a02 - a20;
		end else begin
			d_c[0] = a02 + a20;
			d_c[1] = a12 + a21;
			d_c[2] = rz;
			d_c[3] = a10 - a01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= d_c;
		end
	end

endmodule

/* rtl/rm2q_sqrt.sv */
module rm2q_sqrt #(
	parameter int SW = 19,
	parameter int PW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic v_in,
	input  logic [2*SW-1:0] l,
	input  logic [PW-1:0] pay,
	output logic v_out,
	output logic [SW-1:0] root,
	output logic [PW-1:0] pay_out
);

	localparam int LW = 2 * SW;

	logic [LW-1:0] rem_s [SW];
	logic [SW-1:0] root_s [SW];
	logic [PW-1:0] pay_s [SW];
	logic v_s [SW];

	// One root bit per stage, most significant first; the remainder keeps L - root^2.
	for (genvar j = 0; j < SW; j++) begin : g_st
		localparam int K = SW - 1 - j;
		logic [LW-1:0] rem_i;
		logic [SW-1:0] root_i;
		logic [PW-1:0] pay_i;
		logic v_i;
		logic [LW:0] trial;
		logic take;

		if (j == 0) begin : g_first
			assign rem_i = l;
			assign root_i = '0;
			assign pay_i = pay;
			assign v_i = v_in;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign pay_i = pay_s[j-1];
			assign v_i = v_s[j-1];
		end

		assign trial = ((LW+1)'(root_i) << (K + 1)) + ((LW+1)'(1) << (2 * K));
		assign take = {1'b0, rem_i} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= take ? LW'({1'b0, rem_i} - trial) : rem_i;
				root_s[j] <= take ? (root_i | (SW'(1) << K)) : root_i;
				pay_s[j] <= pay_i;
			end
		end
	end

	assign v_out = v_s[SW-1];
	assign root = root_s[SW-1];
	assign pay_out = pay_s[SW-1];

endmodule

/* rtl/rm2q_div.sv */
module rm2q_div #(
	parameter int FRAC_BITS = 14,
	parameter int MW = 18,
	parameter int PW = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic v_in,
	input  logic [rm2q_pkg::LANES-1:0][MW-1:0] mag,
	input  logic [MW:0] s,
	input  logic [PW-1:0] pay,
	output logic v_out,
	output logic [rm2q_pkg::LANES-1:0][FRAC_BITS:0] q,
	output logic [PW-1:0] pay_out
);

	localparam int SW = MW + 1;
	localparam int NW = MW + FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 1;
	localparam int NS = FRAC_BITS + 2;

	logic [rm2q_pkg::LANES-1:0][NW-1:0] rem_s [NS];
	logic [rm2q_pkg::LANES-1:0][QW-1:0] q_s [NS];
	logic [SW-1:0] s_s [NS];
	logic [PW-1:0] pay_s [NS];
	logic v_s [NS];

	// First stage forms the rounded numerator |d| * ONE + s/2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < rm2q_pkg::LANES; i++) begin
				rem_s[0][i] <= (NW'(mag[i]) << FRAC_BITS) + NW'(s >> 1);
				q_s[0][i] <= '0;
			end
			s_s[0] <= s;
			pay_s[0] <= pay;
		end
	end

	// Restoring division, one quotient bit per stage in every lane.
	for (genvar n = 1; n < NS; n++) begin : g_st
		localparam int B = NS - 1 - n;
		logic [NW-1:0] dsh;
		logic [rm2q_pkg::LANES-1:0][NW-1:0] rem_n;
		logic [rm2q_pkg::LANES-1:0][QW-1:0] q_n;

		assign dsh = NW'(s_s[n-1]) << B;

		always_comb begin
			for (int i = 0; i < rm2q_pkg::LANES; i++) begin
				if (rem_s[n-1][i] >= dsh) begin
					rem_n[i] = rem_s[n-1][i] - dsh;
					q_n[i] = q_s[n-1][i] | (QW'(1) << B);
				end else begin
					rem_n[i] = rem_s[n-1][i];
					q_n[i] = q_s[n-1][i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[n] <= 1'b0;
			end else if (adv) begin
				v_s[n] <= v_s[n-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[n] <= rem_n;
				q_s[n] <= q_n;
				s_s[n] <= s_s[n-1];
				pay_s[n] <= pay_s[n-1];
			end
		end
	end

	assign v_out = v_s[NS-1];
	assign q = q_s[NS-1];
	assign pay_out = pay_s[NS-1];

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Channel  Direction  Handshake             Payload
// in       to block   in_valid / in_stall   m_r0c0 .. m_r2c2, signed Q1.FRAC_BITS
// out      from block out_valid / out_stall quat_x, quat_y, quat_z, quat_w, degenerate
//
// One item can enter every cycle while in_stall is low. The square root and the
// divider each settle one bit per stage and make up most of the pipeline.
// Reset clears only the valid bits of the stages; data registers are not reset.
// All stages move together; they hold only while a finished item waits at the
// output and out_stall is high, and bubbles in between hold along with them.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [15:0] m_r0c0,
	input  logic [15:0] m_r1c0,
	input  logic [15:0] m_r2c0,
	input  logic [15:0] m_r0c1,
	input  logic [15:0] m_r1c1,
	input  logic [15:0] m_r2c1,
	input  logic [15:0] m_r0c2,
	input  logic [15:0] m_r1c2,
	input  logic [15:0] m_r2c2,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] quat_x,
	output logic [15:0] quat_y,
	output logic [15:0] quat_z,
	output logic [15:0] quat_w,
	output logic degenerate
);

	// Direction components are signed; they must hold ONE plus the trace.
	localparam int DW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
	localparam int MW = DW - 1;
	localparam int SW = MW + 1;
	localparam int LW = 2 * SW;
	localparam int QW = FRAC_BITS + 1;
	localparam int OW = (FRAC_BITS + 2 > rm2q_pkg::FIELD_W) ? FRAC_BITS + 2 : rm2q_pkg::FIELD_W;
	localparam int SQ_PW = rm2q_pkg::LANES * MW + rm2q_pkg::LANES + 1;
	localparam int DV_PW = rm2q_pkg::LANES + 1;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

	logic adv;
	rm2q_pkg::field_t [rm2q_pkg::N_ENTRIES-1:0] m_in;

	// The whole pipeline advances unless the output register holds a waiting item.
	assign in_stall = out_valid && out_stall;
	assign adv = !in_stall;

	assign m_in = {m_r2c2, m_r1c2, m_r0c2, m_r2c1, m_r1c1, m_r0c1, m_r2c0, m_r1c0, m_r0c0};

	// Stage 1: branch choice and unnormalized direction.
	logic v_s1;
	logic [rm2q_pkg::LANES-1:0][DW-1:0] d_s1;

	rm2q_dir #(
		.FRAC_BITS(FRAC_BITS),
		.DW(DW)
	) u_dir (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.v_in(in_valid),
		.m(m_in),
		.v_s1(v_s1),
		.d_s1(d_s1)
	);

	// Stage 2: magnitudes, signs and squares.
	logic v_s2;
	logic [rm2q_pkg::LANES-1:0][MW-1:0] mag_s2;
	logic [rm2q_pkg::LANES-1:0] neg_s2;
	logic [rm2q_pkg::LANES-1:0][2*MW-1:0] sq_s2;
	logic [rm2q_pkg::LANES-1:0][MW-1:0] mag_c;

	always_comb begin
		for (int i = 0; i < rm2q_pkg::LANES; i++) begin
			mag_c[i] = d_s1[i][DW-1] ? MW'(-$signed(d_s1[i])) : MW'(d_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < rm2q_pkg::LANES; i++) begin
				mag_s2[i] <= mag_c[i];
				neg_s2[i] <= d_s1[i][DW-1];
				sq_s2[i] <= (2*MW)'(mag_c[i]) * (2*MW)'(mag_c[i]);
			end
		end
	end

	// Stage 3: squared length. A zero length would select the identity.
	logic v_s3;
	logic [LW-1:0] l_s3;
	logic zero_s3;
	logic [rm2q_pkg::LANES-1:0][MW-1:0] mag_s3;
	logic [rm2q_pkg::LANES-1:0] neg_s3;
	logic [LW-1:0] l_c;

	assign l_c = LW'(sq_s2[0]) + LW'(sq_s2[1]) + LW'(sq_s2[2]) + LW'(sq_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s3 <= l_c;
			zero_s3 <= (l_c == '0);
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// Integer square root of the length, one bit per stage.
	logic v_rt;
	logic [SW-1:0] s_rt;
	logic [SQ_PW-1:0] pay_rt;
	logic [rm2q_pkg::LANES-1:0][MW-1:0] mag_rt;
	logic [rm2q_pkg::LANES-1:0] neg_rt;
	logic zero_rt;

	rm2q_sqrt #(
		.SW(SW),
		.PW(SQ_PW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.v_in(v_s3),
		.l(l_s3),
		.pay({mag_s3, neg_s3, zero_s3}),
		.v_out(v_rt),
		.root(s_rt),
		.pay_out(pay_rt)
	);

	assign {mag_rt, neg_rt, zero_rt} = pay_rt;

	// Rounded division of each magnitude by the root.
	logic v_dv;
	logic [rm2q_pkg::LANES-1:0][QW-1:0] q_dv;
	logic [DV_PW-1:0] pay_dv;
	logic [rm2q_pkg::LANES-1:0] neg_dv;
	logic zero_dv;

	rm2q_div #(
		.FRAC_BITS(FRAC_BITS),
		.MW(MW),
		.PW(DV_PW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.v_in(v_rt),
		.mag(mag_rt),
		.s(s_rt),
		.pay({neg_rt, zero_rt}),
		.v_out(v_dv),
		.q(q_dv),
		.pay_out(pay_dv)
	);

	assign {neg_dv, zero_dv} = pay_dv;

	// Output register: saturation, sign and the identity for a zero length.
	logic [rm2q_pkg::LANES-1:0][rm2q_pkg::FIELD_W-1:0] comp_c;
	logic [rm2q_pkg::LANES-1:0][rm2q_pkg::FIELD_W-1:0] comp_q;
	logic v_q;
	logic deg_q;

	always_comb begin
		logic [QW-1:0] qs;
		logic signed [OW-1:0] sv;
		for (int i = 0; i < rm2q_pkg::LANES; i++) begin
			qs = (q_dv[i] > ONE_Q) ? ONE_Q : q_dv[i];
			sv = neg_dv[i] ? -$signed(OW'(qs)) : $signed(OW'(qs));
			comp_c[i] = sv[rm2q_pkg::FIELD_W-1:0];
		end
		if (zero_dv) begin
			comp_c[0] = '0;
			comp_c[1] = '0;
			comp_c[2] = '0;
			sv = $signed(OW'(ONE_Q));
			comp_c[3] = sv[rm2q_pkg::FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			comp_q <= comp_c;
			deg_q <= zero_dv;
		end
	end

	assign out_valid = v_q;
	assign quat_x = comp_q[0];
	assign quat_y = comp_q[1];
	assign quat_z = comp_q[2];
	assign quat_w = comp_q[3];
	assign degenerate = deg_q;

`ifndef SYNTHESIS
	// The trace term is above ONE and the radicand is at least one LSB, so the length never vanishes.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !zero_s3)
		else $error("squared length is zero");

	a_no_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !degenerate)
		else $error("identity given for a valid rotation");

	// A unit quaternion has a component of at least one half.
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (FRAC_BITS <= 14) |->
		(quat_x != '0 || quat_y != '0 || quat_z != '0 || quat_w != '0))
		else $error("normalized quaternion is all zero");
`endif

endmodule

/* test/tb_rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

	localparam int FRAC = 14;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam int N_RANDOM = 1200;
	localparam int CYCLE_LIMIT = 400000;

	// One converted quaternion, as it leaves the block.
	typedef struct packed {
		rm2q_pkg::field_t qx;
		rm2q_pkg::field_t qy;
		rm2q_pkg::field_t qz;
		rm2q_pkg::field_t qw;
		logic   degen;
	} quat_t;

	// One directed row: nine entries and, where it is plain, the known answer.
	typedef struct {
		rm2q_pkg::field_t m[rm2q_pkg::N_ENTRIES];
		bit     known;
		quat_t  q;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rm2q_pkg::field_t m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2;
	logic out_valid;
	logic out_stall;
	logic [15:0] quat_x, quat_y, quat_z, quat_w;
	logic degenerate;

	quat_t quat_fifo[$];
	int mismatches = 0;
	int results_seen = 0;
	int branch_hits[4];
	int cycles = 0;
	bit burst_mode = 0;

	rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.m_r0c0(m_r0c0), .m_r1c0(m_r1c0), .m_r2c0(m_r2c0),
		.m_r0c1(m_r0c1), .m_r1c1(m_r1c1), .m_r2c1(m_r2c1),
		.m_r0c2(m_r0c2), .m_r1c2(m_r1c2), .m_r2c2(m_r2c2),
		.out_valid(out_valid), .out_stall(out_stall),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.degenerate(degenerate)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Integer square root, floor, by the bit-pair method.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Divide one direction component by the length, rounding halves away from zero.
	function automatic rm2q_pkg::field_t unit_component(longint d, longint unsigned s);
		longint unsigned mag;
		longint unsigned q;
		mag = (d < 0) ? -d : d;
		q = ((mag << FRAC) + (s >> 1)) / s;
		if (q > ONE) q = ONE;
		return (d < 0) ? rm2q_pkg::field_t'(-longint'(q)) : rm2q_pkg::field_t'(q);
	endfunction

	// Shepperd's method: pick the trace branch or the branch of the largest diagonal
	// entry, build an unnormalized direction, then scale it to unit length.
	function automatic quat_t matrix_to_quat(rm2q_pkg::field_t m[rm2q_pkg::N_ENTRIES],
		output int branch);
		longint e[rm2q_pkg::N_ENTRIES];
		longint d[4];
		longint tr;
		longint r;
		longint unsigned len;
		longint unsigned s;
		quat_t q;
		for (int i = 0; i < rm2q_pkg::N_ENTRIES; i++) e[i] = longint'($signed(m[i]));
		// Entry order: m00 m10 m20 m01 m11 m21 m02 m12 m22.
		tr = e[0] + e[4] + e[8];
		if (tr > 0) begin
			branch = 0;
			d = '{e[5] - e[7], e[6] - e[2], e[1] - e[3], ONE + tr};
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			branch = 1;
			r = ONE + e[0] - e[4] - e[8];
			if (r < 1) r = 1;
			d = '{r, e[3] + e[1], e[6] + e[2], e[5] - e[7]};
		end else if (e[4] > e[8]) begin
			branch = 2;
			r = ONE + e[4] - e[0] - e[8];
			if (r < 1) r = 1;
			d = '{e[3] + e[1], r, e[7] + e[5], e[6] - e[2]};
		end else begin
			branch = 3;
			r = ONE + e[8] - e[0] - e[4];
			if (r < 1) r = 1;
			d = '{e[6] + e[2], e[7] + e[5], r, e[1] - e[3]};
		end
		len = 0;
		for (int i = 0; i < 4; i++) len += longint'(d[i] * d[i]);
		if (len == 0) begin
			q = '{qx: '0, qy: '0, qz: '0, qw: rm2q_pkg::field_t'(ONE), degen: 1'b1};
		end else begin
			s = floor_sqrt(len);
			q.qx = unit_component(d[0], s);
			q.qy = unit_component(d[1], s);
			q.qz = unit_component(d[2], s);
			q.qw = unit_component(d[3], s);
			q.degen = 1'b0;
		end
		return q;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch on result %0d: %s got %h expected %h",
			results_seen, what, got, want);
		mismatches++;
	endtask

	// Drives one item and holds it until the block takes it. Gaps come before the item.
	task automatic send_matrix(rm2q_pkg::field_t m[rm2q_pkg::N_ENTRIES]);
		while (!burst_mode && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		do @(posedge clk); while (in_stall);
	endtask

	// Queues the prediction, or the typed-in answer of a directed row, then sends.
	task automatic send_item(rm2q_pkg::field_t m[rm2q_pkg::N_ENTRIES], bit known,
		quat_t want);
		quat_t q;
		int br;
		q = matrix_to_quat(m, br);
		branch_hits[br]++;
		quat_fifo.insert(quat_fifo.size(), known ? want : q);
		send_matrix(m);
	endtask

	// A near rotation: a signed permutation of axes with small random noise. It lands
	// in every branch and keeps the diagonal close to the unit extremes.
	function automatic void near_rotation(output rm2q_pkg::field_t m[rm2q_pkg::N_ENTRIES]);
		int perm;
		int col;
		int sg;
		int noise;
		perm = $urandom_range(5);
		noise = 1 << $urandom_range(13);
		for (int c = 0; c < 3; c++) begin
			col = (perm + (perm < 3 ? c : 3 - c)) % 3;
			sg = $urandom_range(1) ? 1 : -1;
			for (int rr = 0; rr < 3; rr++)
				m[c * 3 + rr] = rm2q_pkg::field_t'((rr == col ? sg * int'(ONE) : 0)
					+ int'($urandom_range(2 * noise)) - noise);
		end
	endfunction

	// Receiver: stalls at random, and checks each result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (quat_fifo.size() == 0) begin
					report_mismatch("result with no item waiting", quat_x, 16'h0000);
				end else begin
					quat_t w;
					w = quat_fifo.pop_front();
					if (quat_x !== w.qx) report_mismatch("quat_x", quat_x, w.qx);
					if (quat_y !== w.qy) report_mismatch("quat_y", quat_y, w.qy);
					if (quat_z !== w.qz) report_mismatch("quat_z", quat_z, w.qz);
					if (quat_w !== w.qw) report_mismatch("quat_w", quat_w, w.qw);
					if (degenerate !== w.degen)
						report_mismatch("degenerate", 16'(degenerate), 16'(w.degen));
				end
				results_seen++;
			end
			out_stall <= !burst_mode && ($urandom_range(99) < 21);
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		rm2q_pkg::field_t m[rm2q_pkg::N_ENTRIES];
		quat_t ident;
		localparam rm2q_pkg::field_t P = 16'sd16384;
		localparam rm2q_pkg::field_t N = -16'sd16384;
		int wait_cycles;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity, and the three half turns, which leave one branch each with a known
		// unit answer; ties and extremes are predicted.
		ident = '{qx: 0, qy: 0, qz: 0, qw: P, degen: 0};
		rows.insert(rows.size(), '{'{P, 0, 0, 0, P, 0, 0, 0, P}, 1, ident});
		rows.insert(rows.size(), '{'{P, 0, 0, 0, N, 0, 0, 0, N}, 1,
			'{qx: P, qy: 0, qz: 0, qw: 0, degen: 0}});
		rows.insert(rows.size(), '{'{N, 0, 0, 0, P, 0, 0, 0, N}, 1,
			'{qx: 0, qy: P, qz: 0, qw: 0, degen: 0}});
		rows.insert(rows.size(), '{'{N, 0, 0, 0, N, 0, 0, 0, P}, 1,
			'{qx: 0, qy: 0, qz: P, qw: 0, degen: 0}});
		// All zero entries: trace zero, ties go to the z branch.
		rows.insert(rows.size(), '{'{default: 16'h0000}, 0, ident});
		rows.insert(rows.size(), '{'{default: 16'h7fff}, 0, ident});
		rows.insert(rows.size(), '{'{default: 16'h8000}, 0, ident});
		rows.insert(rows.size(), '{'{default: 16'hffff}, 0, ident});
		rows.insert(rows.size(), '{'{16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 0, ident});
		rows.insert(rows.size(), '{'{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000}, 0, ident});
		// Ties between diagonal entries with a negative trace.
		rows.insert(rows.size(),
			'{'{N, 16'h1000, 0, 0, N, 16'h2000, 0, 0, 16'hc001}, 0, ident});
		rows.insert(rows.size(), '{'{16'hc000, 0, 16'h0100, 16'h0200, 16'hc000, 0,
			0, 16'h0300, 16'hd000}, 0, ident});
		rows.insert(rows.size(), '{'{16'hd000, 16'h7fff, 16'h8000, 16'h8000,
			16'hc000, 16'h7fff, 16'h7fff, 16'h8000, 16'hc000}, 0, ident});
		// Trace exactly one LSB, and a quarter turn about z.
		rows.insert(rows.size(), '{'{16'h0001, 0, 0, 0, 0, 0, 0, 0, 0}, 0, ident});
		rows.insert(rows.size(), '{'{0, P, 0, N, 0, 0, 0, 0, P}, 0, ident});
		rows.insert(rows.size(), '{'{16'h5555, 16'haaaa, 16'h1234, 16'hedcb,
			16'h0f0f, 16'hf0f0, 16'h00ff, 16'hff00, 16'h8001}, 0, ident});
		foreach (rows[i]) begin
			rw = rows[i];
			send_item(rw.m, rw.known, rw.q);
		end

		// Random part. A window in the middle runs with no gaps and no stalls.
		for (int k = 0; k < N_RANDOM; k++) begin
			burst_mode = (k >= 400 && k < 550);
			if ($urandom_range(99) < 75) begin
				near_rotation(m);
			end else begin
				foreach (m[j]) m[j] = rm2q_pkg::field_t'($urandom);
			end
			send_item(m, 0, ident);
		end
		burst_mode = 0;
		in_valid <= 1'b0;

		while (quat_fifo.size() != 0) @(posedge clk);
		wait_cycles = 2 * FRAC + 40;
		repeat (wait_cycles) @(posedge clk);

		$display("checked %0d quaternions from %0d directed and %0d random matrices",
			results_seen, rows.size(), N_RANDOM);
		$display("branch use: trace %0d, x %0d, y %0d, z %0d",
			branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
		if (mismatches == 0 && quat_fifo.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
